@@ src/dlr_pkg.sv @@
// Shared types and constants for the dashed line rasterizer.
`timescale 1ns / 1ps
`default_nettype none

package dlr_pkg;

    // Widths fixed by the item format
    localparam int LEN_W    = 8;
    localparam int COLOUR_W = 16;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DASH_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_LENGTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BRUSH_SIZE  = 2'd2;

    // Register values after reset
    localparam logic [LEN_W-1:0] DASH_LENGTH_RST = 8'd5;
    localparam logic [LEN_W-1:0] GAP_LENGTH_RST  = 8'd5;
    localparam logic [LEN_W-1:0] BRUSH_SIZE_RST  = 8'd1;

    // Item kind carried on the input tuser
    typedef enum logic {
        ACT_START = 1'b0,
        ACT_STEP  = 1'b1
    } action_t;

    // Configuration register set handed to the line walker
    typedef struct packed {
        logic [LEN_W-1:0] dash_length;
        logic [LEN_W-1:0] gap_length;
        logic [LEN_W-1:0] brush_size;
    } cfg_t;

endpackage

`default_nettype wire

@@ src/dlr_walker.sv @@
// Bresenham line walker with dash counter and brush edge computation.
`timescale 1ns / 1ps
`default_nettype none

module dlr_walker #(
    parameter int COORD_BITS = 10
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    input  wire dlr_pkg::action_t              in_action,
    input  wire logic [COORD_BITS-1:0]         start_x,
    input  wire logic [COORD_BITS-1:0]         start_y,
    input  wire logic [COORD_BITS-1:0]         end_x,
    input  wire logic [COORD_BITS-1:0]         end_y,
    input  wire logic [dlr_pkg::COLOUR_W-1:0]  line_colour_in,
    input  wire dlr_pkg::cfg_t                 cfg,
    output logic                               out_valid,
    // pixel_x, pixel_y, brush_x_end, brush_y_end, pixel_colour
    output logic [4*COORD_BITS+dlr_pkg::COLOUR_W-1:0] out_data,
    output logic                               out_paint,
    output logic                               out_last,
    output logic                               line_active
);

    localparam int CB    = COORD_BITS;
    localparam int ERR_W = COORD_BITS + 2;
    localparam int LEN_W = dlr_pkg::LEN_W;

    // Line state
    logic [CB-1:0]                  cursor_x_reg, cursor_x_next;
    logic [CB-1:0]                  cursor_y_reg, cursor_y_next;
    logic [CB-1:0]                  target_x_reg, target_x_next;
    logic [CB-1:0]                  target_y_reg, target_y_next;
    logic                           x_goes_down_reg, x_goes_down_next;
    logic                           y_goes_down_reg, y_goes_down_next;
    logic [CB-1:0]                  span_x_reg, span_x_next;
    logic [CB-1:0]                  span_y_reg, span_y_next;
    logic signed [ERR_W-1:0]        error_term_reg, error_term_next;
    logic [LEN_W-1:0]               dash_phase_reg, dash_phase_next;
    logic                           in_dash_reg, in_dash_next;
    logic                           line_active_reg, line_active_next;
    logic [dlr_pkg::COLOUR_W-1:0]   held_colour_reg, held_colour_next;

    // Step arithmetic
    logic                           at_end;
    logic                           do_step;
    logic [LEN_W-1:0]               seg_len;
    logic [LEN_W:0]                 phase_inc;
    logic signed [ERR_W:0]          e2;
    logic signed [ERR_W:0]          span_x_ext;
    logic signed [ERR_W:0]          span_y_ext;
    logic signed [ERR_W:0]          err_sum;
    logic                           move_x;
    logic                           move_y;
    logic                           start_x_down;
    logic                           start_y_down;
    logic [CB-1:0]                  start_span_x;
    logic [CB-1:0]                  start_span_y;

    // Brush edge
    logic [LEN_W-1:0]               brush_m1;
    logic [CB:0]                    bx_sum;
    logic [CB:0]                    by_sum;
    logic [CB-1:0]                  brush_x_end;
    logic [CB-1:0]                  brush_y_end;

    assign at_end  = (cursor_x_reg == target_x_reg) && (cursor_y_reg == target_y_reg);
    assign do_step = in_valid && (in_action == dlr_pkg::ACT_STEP) && line_active_reg;

    // Start: direction and span of each axis
    assign start_x_down = end_x < start_x;
    assign start_y_down = end_y < start_y;
    assign start_span_x = start_x_down ? (start_x - end_x) : (end_x - start_x);
    assign start_span_y = start_y_down ? (start_y - end_y) : (end_y - start_y);

    // Dash counter advance
    assign seg_len   = in_dash_reg ? cfg.dash_length : cfg.gap_length;
    assign phase_inc = {1'b0, dash_phase_reg} + (LEN_W+1)'(1);

    // Bresenham decision on twice the error
    assign span_x_ext = $signed({3'b000, span_x_reg});
    assign span_y_ext = $signed({3'b000, span_y_reg});
    assign e2         = $signed({error_term_reg, 1'b0});
    assign move_x     = e2 >= -span_y_ext;
    assign move_y     = e2 <= span_x_ext;
    assign err_sum    = $signed({error_term_reg[ERR_W-1], error_term_reg})
                        - (move_x ? span_y_ext : '0)
                        + (move_y ? span_x_ext : '0);

    // Next state
    always_comb begin
        cursor_x_next    = cursor_x_reg;
        cursor_y_next    = cursor_y_reg;
        target_x_next    = target_x_reg;
        target_y_next    = target_y_reg;
        x_goes_down_next = x_goes_down_reg;
        y_goes_down_next = y_goes_down_reg;
        span_x_next      = span_x_reg;
        span_y_next      = span_y_reg;
        error_term_next  = error_term_reg;
        dash_phase_next  = dash_phase_reg;
        in_dash_next     = in_dash_reg;
        line_active_next = line_active_reg;
        held_colour_next = held_colour_reg;

        if (in_valid && (in_action == dlr_pkg::ACT_START)) begin
            // load a new line, abandoning any running one
            cursor_x_next    = start_x;
            cursor_y_next    = start_y;
            target_x_next    = end_x;
            target_y_next    = end_y;
            x_goes_down_next = start_x_down;
            y_goes_down_next = start_y_down;
            span_x_next      = start_span_x;
            span_y_next      = start_span_y;
            error_term_next  = $signed({2'b00, start_span_x}) - $signed({2'b00, start_span_y});
            dash_phase_next  = '0;
            in_dash_next     = 1'b1;
            line_active_next = 1'b1;
            held_colour_next = line_colour_in;
        end else if (do_step) begin
            // advance the dash pattern
            if (phase_inc >= {1'b0, seg_len}) begin
                dash_phase_next = '0;
                in_dash_next    = !in_dash_reg;
            end else begin
                dash_phase_next = phase_inc[LEN_W-1:0];
            end
            // walk one pixel, or finish at the endpoint
            if (at_end) begin
                line_active_next = 1'b0;
            end else begin
                error_term_next = err_sum[ERR_W-1:0];
                if (move_x) begin
                    cursor_x_next = x_goes_down_reg ? cursor_x_reg - 1'b1
                                                    : cursor_x_reg + 1'b1;
                end
                if (move_y) begin
                    cursor_y_next = y_goes_down_reg ? cursor_y_reg - 1'b1
                                                    : cursor_y_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_x_reg    <= '0;
            cursor_y_reg    <= '0;
            target_x_reg    <= '0;
            target_y_reg    <= '0;
            x_goes_down_reg <= 1'b0;
            y_goes_down_reg <= 1'b0;
            span_x_reg      <= '0;
            span_y_reg      <= '0;
            error_term_reg  <= '0;
            dash_phase_reg  <= '0;
            in_dash_reg     <= 1'b1;
            line_active_reg <= 1'b0;
            held_colour_reg <= '0;
        end else begin
            cursor_x_reg    <= cursor_x_next;
            cursor_y_reg    <= cursor_y_next;
            target_x_reg    <= target_x_next;
            target_y_reg    <= target_y_next;
            x_goes_down_reg <= x_goes_down_next;
            y_goes_down_reg <= y_goes_down_next;
            span_x_reg      <= span_x_next;
            span_y_reg      <= span_y_next;
            error_term_reg  <= error_term_next;
            dash_phase_reg  <= dash_phase_next;
            in_dash_reg     <= in_dash_next;
            line_active_reg <= line_active_next;
            held_colour_reg <= held_colour_next;
        end
    end

    // Brush corner: pixel plus size minus one, a zero size acts as one
    assign brush_m1    = (cfg.brush_size == '0) ? '0 : cfg.brush_size - 1'b1;
    assign bx_sum      = {1'b0, cursor_x_reg} + {{(CB+1-LEN_W){1'b0}}, brush_m1};
    assign by_sum      = {1'b0, cursor_y_reg} + {{(CB+1-LEN_W){1'b0}}, brush_m1};
    assign brush_x_end = bx_sum[CB] ? '1 : bx_sum[CB-1:0];
    assign brush_y_end = by_sum[CB] ? '1 : by_sum[CB-1:0];

    // Result of the current pixel
    assign out_valid   = do_step;
    assign out_data    = {held_colour_reg, brush_y_end, brush_x_end, cursor_y_reg, cursor_x_reg};
    assign out_paint   = in_dash_reg;
    assign out_last    = at_end;
    assign line_active = line_active_reg;

endmodule

`default_nettype wire

@@ src/dlr_outbuf.sv @@
// Two-entry skid buffer holding results until the downstream side takes them.
`timescale 1ns / 1ps
`default_nettype none

module dlr_outbuf #(
    parameter int DATA_W = 58
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [DATA_W-1:0] in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [DATA_W-1:0]      out_data
);

    logic              main_valid_reg;
    logic              skid_valid_reg;
    logic [DATA_W-1:0] main_data_reg;
    logic [DATA_W-1:0] skid_data_reg;

    // Control: the skid entry absorbs a result when the main entry is stalled
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (out_ready) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (in_valid) begin
            if (main_valid_reg && !out_ready) begin
                skid_valid_reg <= 1'b1;
            end else begin
                main_valid_reg <= 1'b1;
            end
        end else if (out_ready) begin
            main_valid_reg <= 1'b0;
        end
    end

    // Payload: move skid into main on transfer, else load incoming result
    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (out_ready) begin
                main_data_reg <= skid_data_reg;
            end
        end else if (in_valid) begin
            if (main_valid_reg && !out_ready) begin
                skid_data_reg <= in_data;
            end else begin
                main_data_reg <= in_data;
            end
        end
    end

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

endmodule

`default_nettype wire

@@ src/dashed_line_rasterizer.sv @@
// Dashed Bresenham line rasterizer with square brush: top level.
// A step item's result is registered in the output buffer before it shows on m_tvalid.
// Throughput: one item per cycle while s_tready is high; each step is combinational.
// A two-entry output skid buffer keeps s_tready high while one result waits downstream.
// Reset (synchronous, aresetn low): no line active, dash 5, gap 5, brush 1, buffer empty.
`timescale 1ns / 1ps
`default_nettype none

module dashed_line_rasterizer #(
    parameter int COORD_BITS = 10
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // start_x, start_y, end_x, end_y, line_colour_in
    input  wire logic [((4*COORD_BITS+dlr_pkg::COLOUR_W+7)/8)*8-1:0] s_tdata,
    // action
    input  wire logic                  s_tuser,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // pixel_x, pixel_y, brush_x_end, brush_y_end, pixel_colour
    output logic [((4*COORD_BITS+dlr_pkg::COLOUR_W+7)/8)*8-1:0] m_tdata,
    // paint
    output logic                       m_tuser,
    output logic                       m_tlast,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [dlr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [dlr_pkg::LEN_W-1:0]     cfg_data
);

    localparam int CB       = COORD_BITS;
    localparam int FIELDS_W = 4*COORD_BITS + dlr_pkg::COLOUR_W;
    localparam int BUF_W    = FIELDS_W + 2;
    localparam int TDATA_W  = ((FIELDS_W + 7) / 8) * 8;

    dlr_pkg::cfg_t       cfg_reg, cfg_next;
    logic                in_xfer;
    logic                walk_valid;
    logic [FIELDS_W-1:0] walk_data;
    logic                walk_paint;
    logic                walk_last;
    logic                line_active;
    logic                buf_ready;
    logic [BUF_W-1:0]    buf_out;

    // Configuration registers, always ready
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                dlr_pkg::REG_DASH_LENGTH: cfg_next.dash_length = cfg_data;
                dlr_pkg::REG_GAP_LENGTH:  cfg_next.gap_length  = cfg_data;
                dlr_pkg::REG_BRUSH_SIZE:  cfg_next.brush_size  = cfg_data;
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dash_length <= dlr_pkg::DASH_LENGTH_RST;
            cfg_reg.gap_length  <= dlr_pkg::GAP_LENGTH_RST;
            cfg_reg.brush_size  <= dlr_pkg::BRUSH_SIZE_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Input transfer
    assign s_tready = buf_ready;
    assign in_xfer  = s_tvalid && buf_ready;

    dlr_walker #(
        .COORD_BITS (COORD_BITS)
    ) u_walker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (in_xfer),
        .in_action      (dlr_pkg::action_t'(s_tuser)),
        .start_x        (s_tdata[CB-1:0]),
        .start_y        (s_tdata[2*CB-1:CB]),
        .end_x          (s_tdata[3*CB-1:2*CB]),
        .end_y          (s_tdata[4*CB-1:3*CB]),
        .line_colour_in (s_tdata[FIELDS_W-1:4*CB]),
        .cfg            (cfg_reg),
        .out_valid      (walk_valid),
        .out_data       (walk_data),
        .out_paint      (walk_paint),
        .out_last       (walk_last),
        .line_active    (line_active)
    );

    dlr_outbuf #(
        .DATA_W (BUF_W)
    ) u_outbuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (walk_valid),
        .in_ready  (buf_ready),
        .in_data   ({walk_last, walk_paint, walk_data}),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (buf_out)
    );

    // Unpack the buffered result
    assign m_tdata = TDATA_W'(buf_out[FIELDS_W-1:0]);
    assign m_tuser = buf_out[FIELDS_W];
    assign m_tlast = buf_out[FIELDS_W+1];

    // Reset leaves the block ready with nothing to send
    assert property (@(posedge aclk) !aresetn |=> s_tready && !m_tvalid)
        else $error("not ready or result pending after reset");

    // A start transfer always leaves a line running
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && (s_tuser == dlr_pkg::ACT_START)) |=> line_active)
        else $error("start transfer did not begin a line");

    // The endpoint result ends the line
    assert property (@(posedge aclk) disable iff (!aresetn)
        (walk_valid && walk_last) |=> !line_active)
        else $error("line still active after its endpoint");

endmodule

`default_nettype wire
